[sv/modexp_pkg.sv]
// Shared types for the modular exponentiation block.
`default_nettype none
package modexp_pkg;

	// Status of the shared modular multiplier.
	typedef struct packed {
		logic busy;
		logic done;
	} mm_status_t;

endpackage
`default_nettype wire

[sv/modexp_mulmod.sv]
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle.
`default_nettype none
module modexp_mulmod import modexp_pkg::*; #(
	parameter int MOD_BITS = 18
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [MOD_BITS-1:0] a,
	input  wire logic [MOD_BITS-1:0] b,
	input  wire logic [MOD_BITS-1:0] m,
	output mm_status_t               status,
	output logic      [MOD_BITS-1:0] result
);

	localparam int W     = MOD_BITS + 2;
	localparam int CNT_W = $clog2(MOD_BITS + 1);

	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] m_q;
	logic [MOD_BITS-1:0] r_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [W-1:0]        t;
	logic [W:0]          d1;
	logic [W:0]          d2;
	logic [MOD_BITS-1:0] r_nxt;

	// r < m and b < m, so 2r + b stays below 3m: one of two subtractions settles it.
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + (a_q[MOD_BITS-1] ? W'(b_q) : W'(0));
		d1 = {1'b0, t} - {3'b000, m_q};
		d2 = {1'b0, t} - {2'b00, m_q, 1'b0};
		if (!d2[W]) begin
			r_nxt = d2[MOD_BITS-1:0];
		end else if (!d1[W]) begin
			r_nxt = d1[MOD_BITS-1:0];
		end else begin
			r_nxt = t[MOD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(MOD_BITS);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[MOD_BITS-2:0], 1'b0};
			r_q <= r_nxt;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign result      = r_q;

endmodule
`default_nettype wire

[sv/modular_exponentiation.sv]
// Modular exponentiation by square-and-multiply on a bit-serial modular multiplier.
// When the modulus is below 2 the result is zero and no product is computed;
// otherwise the products run on the multiplier in turn: one product reduces the base,
// then each exponent bit below the highest set one costs a squaring and each set bit a multiply.
// One item at a time; s_tready rises in the same cycle as output valid, so the next transfer can be taken then.
// Reset: arst_n clears control and output valid at once and sets the modulus to 1.
`default_nettype none
module modular_exponentiation import modexp_pkg::*; #(
	parameter int MOD_BITS = 18,
	parameter int EXP_BITS = 63
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// s_tdata fields from bit 0: base, exponent
	input  wire logic                                        s_tvalid,
	output logic                                             s_tready,
	input  wire logic [((MOD_BITS+EXP_BITS+7)/8)*8-1:0]      s_tdata,
	// m_tdata fields from bit 0: power_mod
	output logic                                             m_tvalid,
	input  wire logic                                        m_tready,
	output logic [((MOD_BITS+7)/8)*8-1:0]                    m_tdata,
	input  wire logic                                        cfg_valid,
	output logic                                             cfg_ready,
	input  wire logic [MOD_BITS-1:0]                         cfg_data
);

	localparam int OUT_W = ((MOD_BITS + 7) / 8) * 8;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SQR  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);

	logic [2:0]          state_q;
	logic                start_q;
	logic [MOD_BITS-1:0] mod_q;
	logic [MOD_BITS-1:0] base_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] sq_q;
	logic [MOD_BITS-1:0] res_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic [MOD_BITS-1:0] mm_a;
	logic [MOD_BITS-1:0] mm_b;
	logic [MOD_BITS-1:0] mm_res;
	mm_status_t          mm_st;
	logic                in_xfer;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_comb begin
		case (state_q)
			ST_RED: begin
				mm_a = base_q;
				mm_b = ONE;
			end
			ST_MUL: begin
				mm_a = acc_q;
				mm_b = sq_q;
			end
			default: begin
				mm_a = sq_q;
				mm_b = sq_q;
			end
		endcase
	end

	modexp_mulmod #(
		.MOD_BITS(MOD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (mm_a),
		.b      (mm_b),
		.m      (mod_q),
		.status (mm_st),
		.result (mm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= ONE;
		end else if (cfg_valid && cfg_ready) begin
			mod_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (mod_q < MOD_BITS'(2)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_RED;
							start_q <= 1'b1;
						end
					end
				end
				ST_RED: begin
					if (mm_st.done) begin
						if (exp_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= exp_q[0] ? ST_MUL : ST_SQR;
							start_q <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					if (mm_st.done) begin
						if (exp_q[EXP_BITS-1:1] == '0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SQR;
							start_q <= 1'b1;
						end
					end
				end
				ST_SQR: begin
					// the remaining exponent is nonzero here, so another bit follows
					if (mm_st.done) begin
						state_q <= exp_q[1] ? ST_MUL : ST_SQR;
						start_q <= 1'b1;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					base_q <= s_tdata[MOD_BITS-1:0];
					exp_q  <= s_tdata[MOD_BITS+EXP_BITS-1:MOD_BITS];
					res_q  <= '0;
				end
			end
			ST_RED: begin
				if (mm_st.done) begin
					sq_q  <= mm_res;
					acc_q <= ONE;
					res_q <= ONE;
				end
			end
			ST_MUL: begin
				if (mm_st.done) begin
					acc_q <= mm_res;
					res_q <= mm_res;
				end
			end
			ST_SQR: begin
				if (mm_st.done) begin
					sq_q  <= mm_res;
					exp_q <= {1'b0, exp_q[EXP_BITS-1:1]};
				end
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= OUT_W'(res_q);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_mm_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(mm_st.done && state_q != ST_IDLE) |-> (mm_res < mod_q))
		else $error("modular product not reduced below the modulus");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> mm_st.busy)
		else $error("multiplier did not start");

	a_exp_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_SQR) |-> (exp_q != '0))
		else $error("exponent step with no bits left");
`endif

endmodule
`default_nettype wire

[dv/modexp_checker.sv]
// Checker for the modular exponentiation block: tracks the modulus, predicts and compares results.
module modexp_checker #(
	parameter int MOD_BITS = 18,
	parameter int EXP_BITS = 63
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	input  wire logic                                   s_tready,
	// s_tdata fields from bit 0: base, exponent
	input  wire logic [((MOD_BITS+EXP_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic                                   m_tvalid,
	input  wire logic                                   m_tready,
	// m_tdata fields from bit 0: power_mod
	input  wire logic [((MOD_BITS+7)/8)*8-1:0]          m_tdata,
	input  wire logic                                   cfg_valid,
	input  wire logic                                   cfg_ready,
	input  wire logic [MOD_BITS-1:0]                    cfg_data,
	output int                                          errors,
	output int                                          pending
);

	localparam int REPORT_LIMIT = 10;

	logic [MOD_BITS-1:0] modulus_copy;
	logic [MOD_BITS-1:0] power_q[$];
	int                  reported;

	// Square-and-multiply over every exponent bit, LSB first; operands stay below 2^32.
	function automatic logic [MOD_BITS-1:0] expected_power(
		input logic [MOD_BITS-1:0] b,
		input logic [EXP_BITS-1:0] e,
		input logic [MOD_BITS-1:0] m
	);
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] mm;
		mm = 64'(m);
		if (mm < 64'd2) begin
			return '0;
		end
		acc = 64'd1;
		sq  = 64'(b) % mm;
		for (int i = 0; i < EXP_BITS; i++) begin
			if (e[i]) begin
				acc = (acc * sq) % mm;
			end
			sq = (sq * sq) % mm;
		end
		return acc[MOD_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [MOD_BITS-1:0] want;
		logic [MOD_BITS-1:0] got;
		if (!arst_n) begin
			modulus_copy = MOD_BITS'(1);
			power_q.delete();
			errors   <= 0;
			pending  <= 0;
			reported = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				modulus_copy = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				power_q.push_back(expected_power(s_tdata[MOD_BITS-1:0],
					s_tdata[MOD_BITS+EXP_BITS-1:MOD_BITS], modulus_copy));
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[MOD_BITS-1:0];
				if (power_q.size() == 0) begin
					errors <= errors + 1;
					if (reported < REPORT_LIMIT) begin
						$display("unexpected result: power_mod %0d with nothing outstanding", got);
					end
					reported++;
				end else begin
					want = power_q.pop_front();
					if (got !== want) begin
						errors <= errors + 1;
						if (reported < REPORT_LIMIT) begin
							$display("power_mod mismatch: expected %0d, got %0d", want, got);
						end
						reported++;
					end
				end
			end
			pending <= power_q.size();
		end
	end

endmodule

[dv/testbench.sv]
// Top of the modular exponentiation testbench: clock, reset, stimulus and verdict.
module testbench;

	localparam int MOD_BITS       = 18;
	localparam int EXP_BITS       = 63;
	localparam int S_W            = ((MOD_BITS + EXP_BITS + 7) / 8) * 8;
	localparam int M_W            = ((MOD_BITS + 7) / 8) * 8;
	localparam int MOD_MAX        = (1 << MOD_BITS) - 1;
	localparam int RANDOM_PHASES  = 9;
	localparam int PHASE_ITEMS    = 28;
	localparam int HOLD_PHASE     = 6;
	localparam int RX_HOLD_CYCLES = 8000;
	// one full-length item is at most 126 products
	localparam int DRAIN_CYCLES   = 3000;
	localparam int CYCLE_LIMIT    = 3000000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	// s_tdata fields from bit 0: base, exponent
	logic [S_W-1:0]   s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	// m_tdata fields from bit 0: power_mod
	logic [M_W-1:0]   m_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [MOD_BITS-1:0] cfg_data = '0;

	int errors;
	int pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic want_hold = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   cycle_count = 0;
	int   cur_modulus = 1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	modular_exponentiation #(
		.MOD_BITS(MOD_BITS),
		.EXP_BITS(EXP_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	modexp_checker #(
		.MOD_BITS(MOD_BITS),
		.EXP_BITS(EXP_BITS)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	// Result side: random stalls, plus one long hold-off started by a request from stimulus.
	always @(posedge clk) begin
		hold_seen <= want_hold;
		if (want_hold && !hold_seen) begin
			hold_left <= RX_HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[modular_exponentiation] ERROR");
			$finish;
		end
	end

	task automatic send_operands(input logic [MOD_BITS-1:0] b, input logic [EXP_BITS-1:0] e);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= S_W'({e, b});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_modulus(input int value);
		// drop the last offer so it is not taken again while draining
		s_tvalid <= 1'b0;
		wait_drained();
		cfg_data  <= MOD_BITS'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		cur_modulus = value;
	endtask

	function automatic logic [MOD_BITS-1:0] pick_base();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return MOD_BITS'(MOD_MAX);
			2: return MOD_BITS'(cur_modulus - 1);
			3: return MOD_BITS'(cur_modulus);
			default: return MOD_BITS'($urandom_range(0, MOD_MAX));
		endcase
	endfunction

	// Mostly short exponents keep the run fast; one in five spans the full width.
	function automatic logic [EXP_BITS-1:0] pick_exponent();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		if ($urandom_range(0, 4) != 0) begin
			raw &= (64'd1 << $urandom_range(0, 20)) - 64'd1;
		end
		return raw[EXP_BITS-1:0];
	endfunction

	initial begin
		logic [EXP_BITS-1:0] ones;
		logic [EXP_BITS-1:0] alt;
		int                  phase_modulus[RANDOM_PHASES];
		int                  m;
		ones = '1;
		alt  = EXP_BITS'({(EXP_BITS + 1) / 2{2'b01}});
		phase_modulus = '{262139, 3, 0, MOD_MAX, 65536, 0, 2, 0, 0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 17;
		rx_idle_pct <= 62;

		// reset modulus of one: everything reduces to zero
		send_operands('0, '0);
		send_operands(MOD_BITS'(MOD_MAX), ones);
		send_operands(MOD_BITS'(5), EXP_BITS'(3));

		write_modulus(MOD_MAX);
		send_operands('0, '0);
		send_operands('0, EXP_BITS'(1));
		send_operands(MOD_BITS'(MOD_MAX), '0);
		send_operands(MOD_BITS'(MOD_MAX), EXP_BITS'(1));
		send_operands(MOD_BITS'(MOD_MAX - 1), ones);
		send_operands(MOD_BITS'(1), ones);
		send_operands(MOD_BITS'(3), EXP_BITS'(1) << (EXP_BITS - 1));
		send_operands(MOD_BITS'(12345), alt);
		send_operands(MOD_BITS'(18'h2aaaa), ~alt);
		send_operands(MOD_BITS'(18'h15555), ones);
		send_operands(MOD_BITS'(2), EXP_BITS'(62));

		write_modulus(2);
		send_operands(MOD_BITS'(1), '0);
		send_operands(MOD_BITS'(3), ones);
		send_operands(MOD_BITS'(4), EXP_BITS'(7));

		write_modulus(1);
		send_operands(MOD_BITS'(7), EXP_BITS'(9));
		send_operands(MOD_BITS'(MOD_MAX), '0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p / 3)
				0: begin
					tx_idle_pct = 17;
					rx_idle_pct <= 62;
				end
				1: begin
					tx_idle_pct = 62;
					rx_idle_pct <= 17;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
				end
			endcase
			m = phase_modulus[p];
			if (m == 0) begin
				m = $urandom_range(2, MOD_MAX);
			end
			write_modulus(m);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// stall the result side long enough for the input to back up
				if (p == HOLD_PHASE && i == 0) begin
					want_hold <= 1'b1;
				end else if (p == HOLD_PHASE && i == 3) begin
					want_hold <= 1'b0;
				end
				send_operands(pick_base(), pick_exponent());
			end
		end
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[modular_exponentiation] OK");
		end else begin
			$display("[modular_exponentiation] ERROR");
		end
		$finish;
	end

endmodule
